/* design/mpma_pkg.sv */
// ----------------------------------------------------------------------------
// mpma_pkg: shared types and constants of the per-minute averager
// Field widths, command and register codes, the store entry layout and the
// reset values of the window min/max speed registers.
// ----------------------------------------------------------------------------
package mpma_pkg;

  // Default number of minute bins
  localparam int MINUTES_PER_DAY = 1440;
  // Samples from a day at or beyond this index are ignored
  localparam int MAX_DAYS        = 64;
  localparam int FRACTION_BITS   = 4;

  // Field widths
  localparam int CMD_W    = 2;
  localparam int MINUTE_W = 11;
  localparam int DAY_W    = 6;
  localparam int EVENT_W  = 16;
  localparam int VAL_W    = 24;
  localparam int SUM_W    = 30;
  localparam int COUNT_W  = 7;
  localparam int N_SUMS   = 5;

  // Configuration port widths
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // Commands
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DAY_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_END   = 2'd2;

  // Register reset values
  localparam logic [COUNT_W-1:0]  DAY_COUNT_RESET  = 7'd1;
  localparam logic [MINUTE_W-1:0] PEAK_START_RESET = 11'(8 * 60);
  localparam logic [MINUTE_W-1:0] PEAK_END_RESET   = 11'(9 * 60);

  // Window speed reset values: 200.0 and 0
  localparam logic [VAL_W-1:0] LOWEST_RESET  = VAL_W'(200 << FRACTION_BITS);
  localparam logic [VAL_W-1:0] HIGHEST_RESET = '0;

  // A bin stops taking samples at this count
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // One store entry: bin count and the five running sums
  typedef struct packed {
    logic [COUNT_W-1:0]             count;
    logic [N_SUMS-1:0][SUM_W-1:0]   sum;
  } entry_t;

endpackage

/* design/mpma_ifs.sv */
// ----------------------------------------------------------------------------
// mpma_ifs: channel interfaces of the per-minute averager
// Command channel, result channel and configuration write channel, each a
// valid/ready handshake with its payload.
// ----------------------------------------------------------------------------
interface mpma_req_if;
  logic                              valid;
  logic                              ready;
  logic [mpma_pkg::CMD_W-1:0]        command;
  logic [mpma_pkg::MINUTE_W-1:0]     minute;
  logic [mpma_pkg::DAY_W-1:0]        day;
  logic [mpma_pkg::EVENT_W-1:0]      event_code;
  logic [mpma_pkg::VAL_W-1:0]        speed;
  logic [mpma_pkg::VAL_W-1:0]        flow;
  logic [mpma_pkg::VAL_W-1:0]        cumulative_flow;
  logic [mpma_pkg::VAL_W-1:0]        density;
  logic [mpma_pkg::VAL_W-1:0]        travel_time_index;

  modport source (
    output valid, command, minute, day, event_code, speed, flow,
           cumulative_flow, density, travel_time_index,
    input  ready
  );
  modport sink (
    input  valid, command, minute, day, event_code, speed, flow,
           cumulative_flow, density, travel_time_index,
    output ready
  );
endinterface

interface mpma_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [mpma_pkg::MINUTE_W-1:0]     bin_minute;
  logic [mpma_pkg::COUNT_W-1:0]      sample_count;
  logic [mpma_pkg::VAL_W-1:0]        mean_speed;
  logic [mpma_pkg::VAL_W-1:0]        mean_flow;
  logic [mpma_pkg::VAL_W-1:0]        mean_cumulative_flow;
  logic [mpma_pkg::VAL_W-1:0]        mean_density;
  logic [mpma_pkg::VAL_W-1:0]        mean_travel_time_index;
  logic [mpma_pkg::VAL_W-1:0]        window_min_speed;
  logic [mpma_pkg::VAL_W-1:0]        window_max_speed;

  modport source (
    output valid, bin_minute, sample_count, mean_speed, mean_flow,
           mean_cumulative_flow, mean_density, mean_travel_time_index,
           window_min_speed, window_max_speed,
    input  ready
  );
  modport sink (
    input  valid, bin_minute, sample_count, mean_speed, mean_flow,
           mean_cumulative_flow, mean_density, mean_travel_time_index,
           window_min_speed, window_max_speed,
    output ready
  );
endinterface

interface mpma_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [mpma_pkg::CFG_IDX_W-1:0]    reg_index;
  logic [mpma_pkg::CFG_DATA_W-1:0]   wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

/* design/masked_per_minute_averager.sv */
// Add sample: accept, store read, five passes of the shared saturating adder,
//   write back. Read bin: accept, store read, then one division per sum in the
//   serial divider; an empty bin skips the divisions.
// One item at a time; a finished result waits in the output register while
//   the next item is taken. Reset and a clear command sweep the store to zero,
//   one entry per minute (MINUTES_PER_DAY, 1440 by default); no item is taken during the sweep.
// ----------------------------------------------------------------------------
// masked_per_minute_averager: masked per-minute-of-day averager
// Accumulates filtered samples into per-minute sums and counts, tracks the
// peak-window min/max speed, and returns per-bin means on a read.
// ----------------------------------------------------------------------------
module masked_per_minute_averager #(
  parameter int MINUTES_PER_DAY = mpma_pkg::MINUTES_PER_DAY
) (
  input  logic         clk,
  input  logic         rst,
  mpma_req_if.sink     req,
  mpma_rsp_if.source   rsp,
  mpma_cfg_if.sink     cfg
);

  localparam int AW = (MINUTES_PER_DAY > 1) ? $clog2(MINUTES_PER_DAY) : 1;
  localparam int MW = (AW > mpma_pkg::MINUTE_W) ? AW : mpma_pkg::MINUTE_W;
  localparam int SW = mpma_pkg::SUM_W;
  localparam int VW = mpma_pkg::VAL_W;
  localparam int CW = mpma_pkg::COUNT_W;
  localparam int NS = mpma_pkg::N_SUMS;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MINUTES_PER_DAY - 1);
  localparam logic [2:0]    LAST_IDX  = 3'(NS - 1);

  // Sequencer states
  localparam logic [2:0] S_SWEEP = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_ACC   = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state;

  // Configuration registers
  logic [CW-1:0]                  day_count;
  logic [mpma_pkg::MINUTE_W-1:0]  peak_start;
  logic [mpma_pkg::MINUTE_W-1:0]  peak_end;

  // Window speed tracking
  logic [VW-1:0] lowest_speed;
  logic [VW-1:0] highest_speed;

  // Working item
  logic [mpma_pkg::CMD_W-1:0]     item_cmd;
  logic [mpma_pkg::MINUTE_W-1:0]  item_minute;
  logic                           item_in_range;
  logic [VW-1:0]                  vals [NS];
  logic [SW-1:0]                  sums [NS];
  logic [CW-1:0]                  ent_cnt;
  logic [2:0]                     idx;
  logic [AW-1:0]                  sweep_addr;

  // Result register
  logic                           rsp_valid;
  logic [mpma_pkg::MINUTE_W-1:0]  rsp_minute;
  logic [CW-1:0]                  rsp_count;
  logic [VW-1:0]                  rsp_mean [NS];
  logic [VW-1:0]                  rsp_min;
  logic [VW-1:0]                  rsp_max;

  // Store and divider hookup
  logic               st_rd_en;
  logic [AW-1:0]      st_rd_addr;
  mpma_pkg::entry_t   st_rd_data;
  logic               st_wr_en;
  logic [AW-1:0]      st_wr_addr;
  mpma_pkg::entry_t   st_wr_data;

  logic               div_start;
  logic               div_done;
  logic [SW-1:0]      div_quotient;

  // Handshake decode
  logic                req_fire;
  logic                out_free;
  logic [MW-1:0]       req_min_ext;
  logic [MW-1:0]       item_min_ext;
  logic                req_in_range;
  logic                req_sample_ok;
  logic                item_in_window;

  // Shared saturating adder
  logic [SW:0]         acc_wide;
  logic [SW-1:0]       acc_sat;

  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && (state == S_IDLE);
  assign out_free  = !rsp_valid || rsp.ready;
  assign cfg.ready = 1'b1;

  assign req_min_ext    = MW'(req.minute);
  assign item_min_ext   = MW'(item_minute);
  assign req_in_range   = (32'(req.minute) < 32'(MINUTES_PER_DAY));
  assign req_sample_ok  = req_in_range && (req.event_code == '0) &&
                          ({1'b0, req.day} < day_count) &&
                          (32'(req.day) < 32'(mpma_pkg::MAX_DAYS));
  assign item_in_window = (item_minute >= peak_start) && (item_minute < peak_end);

  assign acc_wide = {1'b0, sums[idx]} + (SW + 1)'(vals[idx]);
  assign acc_sat  = acc_wide[SW] ? '1 : acc_wide[SW-1:0];

  // Store port control: sweep zeros, or write back the updated bin
  always_comb begin
    st_rd_en   = req_fire;
    st_rd_addr = req_min_ext[AW-1:0];
    st_wr_en   = 1'b0;
    st_wr_addr = item_min_ext[AW-1:0];
    st_wr_data = '0;
    if (state == S_SWEEP) begin
      st_wr_en   = 1'b1;
      st_wr_addr = sweep_addr;
    end else if (state == S_WRITE) begin
      st_wr_en         = 1'b1;
      st_wr_data.count = ent_cnt + 1'b1;
      for (int i = 0; i < NS; i++) begin
        st_wr_data.sum[i] = sums[i];
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      day_count  <= mpma_pkg::DAY_COUNT_RESET;
      peak_start <= mpma_pkg::PEAK_START_RESET;
      peak_end   <= mpma_pkg::PEAK_END_RESET;
    end else if (cfg.valid) begin
      case (cfg.reg_index)
        mpma_pkg::REG_DAY_COUNT:  day_count  <= cfg.wdata[CW-1:0];
        mpma_pkg::REG_PEAK_START: peak_start <= cfg.wdata;
        mpma_pkg::REG_PEAK_END:   peak_end   <= cfg.wdata;
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_SWEEP;
      sweep_addr    <= '0;
      div_start     <= 1'b0;
      rsp_valid     <= 1'b0;
      idx           <= '0;
      lowest_speed  <= mpma_pkg::LOWEST_RESET;
      highest_speed <= mpma_pkg::HIGHEST_RESET;
    end else begin
      // Start the divider when a read enters the divide phase and after each quotient
      div_start <= ((state == S_FETCH) && (item_cmd != mpma_pkg::CMD_ADD) &&
                    item_in_range && (st_rd_data.count != '0)) ||
                   ((state == S_DIV) && div_done && (idx != LAST_IDX));
      // Raise the result when the bin is done; drop it once transferred
      if ((state == S_DONE) && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_SWEEP: begin
          sweep_addr <= sweep_addr + 1'b1;
          if (sweep_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_fire) begin
            item_cmd      <= req.command;
            item_minute   <= req.minute;
            item_in_range <= req_in_range;
            vals[0]       <= req.speed;
            vals[1]       <= req.flow;
            vals[2]       <= req.cumulative_flow;
            vals[3]       <= req.density;
            vals[4]       <= req.travel_time_index;
            case (req.command)
              mpma_pkg::CMD_CLEAR: begin
                lowest_speed  <= mpma_pkg::LOWEST_RESET;
                highest_speed <= mpma_pkg::HIGHEST_RESET;
                sweep_addr    <= '0;
                state         <= S_SWEEP;
              end
              mpma_pkg::CMD_ADD: begin
                if (req_sample_ok) begin
                  state <= S_FETCH;
                end
              end
              mpma_pkg::CMD_READ: state <= S_FETCH;
              default: ;
            endcase
          end
        end
        S_FETCH: begin
          // Capture the bin, masked for a minute beyond the store
          ent_cnt <= item_in_range ? st_rd_data.count : '0;
          for (int i = 0; i < NS; i++) begin
            sums[i] <= item_in_range ? st_rd_data.sum[i] : '0;
          end
          idx <= '0;
          if (item_cmd == mpma_pkg::CMD_ADD) begin
            state <= (st_rd_data.count == mpma_pkg::COUNT_MAX) ? S_IDLE : S_ACC;
          end else if (!item_in_range || st_rd_data.count == '0) begin
            // Empty bin: sums are zero, so the means are zero
            state <= S_DONE;
          end else begin
            state <= S_DIV;
          end
        end
        S_ACC: begin
          sums[idx] <= acc_sat;
          idx       <= idx + 1'b1;
          if (idx == LAST_IDX) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (item_in_window) begin
            if (vals[0] < lowest_speed) begin
              lowest_speed <= vals[0];
            end
            if (vals[0] > highest_speed) begin
              highest_speed <= vals[0];
            end
          end
          state <= S_IDLE;
        end
        S_DIV: begin
          // Keep the quotient in place of the sum, then move to the next one
          if (div_done) begin
            sums[idx] <= div_quotient;
            if (idx == LAST_IDX) begin
              state <= S_DONE;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        S_DONE: begin
          // Hold until the output register is free
          if (out_free) begin
            rsp_minute <= item_minute;
            rsp_count  <= ent_cnt;
            for (int i = 0; i < NS; i++) begin
              rsp_mean[i] <= sums[i][VW-1:0];
            end
            rsp_min <= lowest_speed;
            rsp_max <= highest_speed;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  mpma_store #(
    .DEPTH (MINUTES_PER_DAY)
  ) u_store (
    .clk     (clk),
    .rd_en   (st_rd_en),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data)
  );

  mpma_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sums[idx]),
    .divisor  (ent_cnt),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Result channel
  assign rsp.valid                  = rsp_valid;
  assign rsp.bin_minute             = rsp_minute;
  assign rsp.sample_count           = rsp_count;
  assign rsp.mean_speed             = rsp_mean[0];
  assign rsp.mean_flow              = rsp_mean[1];
  assign rsp.mean_cumulative_flow   = rsp_mean[2];
  assign rsp.mean_density           = rsp_mean[3];
  assign rsp.mean_travel_time_index = rsp_mean[4];
  assign rsp.window_min_speed       = rsp_min;
  assign rsp.window_max_speed       = rsp_max;

endmodule

/* design/mpma_store.sv */
// ----------------------------------------------------------------------------
// mpma_store: minute bin store
// Single-port-write, single-port-read memory of bin entries (count and five
// sums), one entry per minute, with registered read data.
// ----------------------------------------------------------------------------
module mpma_store #(
  parameter int DEPTH = mpma_pkg::MINUTES_PER_DAY,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output mpma_pkg::entry_t     rd_data,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  mpma_pkg::entry_t     wr_data
);

  mpma_pkg::entry_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/mpma_div.sv */
// ----------------------------------------------------------------------------
// mpma_div: serial sum-by-count divider
// Restoring radix-2 divider: one quotient bit per cycle, SUM_W quotient bits
// per division. Pulses done for a single cycle once the last bit is in; quotient then holds.
// ----------------------------------------------------------------------------
module mpma_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [mpma_pkg::SUM_W-1:0]      dividend,
  input  logic [mpma_pkg::COUNT_W-1:0]    divisor,
  output logic                            done,
  output logic [mpma_pkg::SUM_W-1:0]      quotient
);

  localparam int SW = mpma_pkg::SUM_W;
  localparam int CW = mpma_pkg::COUNT_W;
  localparam int NW = $clog2(SW);
  localparam logic [NW-1:0] LAST_STEP = NW'(SW - 1);

  logic          busy;
  logic [NW-1:0] step;
  logic [CW-1:0] rem;
  logic [CW-1:0] dvs;
  logic [SW-1:0] quo;

  logic [CW:0]   trial;
  logic          fits;
  logic [CW-1:0] rem_next;
  logic [SW-1:0] quo_next;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    trial    = {rem, quo[SW-1]};
    fits     = (trial >= {1'b0, dvs});
    rem_next = fits ? CW'(trial - {1'b0, dvs}) : trial[CW-1:0];
    quo_next = {quo[SW-2:0], fits};
  end

  // Iterate one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        rem  <= rem_next;
        quo  <= quo_next;
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

/* tb/sv/tb_masked_per_minute_averager.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_masked_per_minute_averager: regression for the per-minute averager
// Drives clear, add, read and unused commands over the request channel and
// writes the day and window registers between phases, with the block idle.
// A behavioral store of per-minute sums, counts and window min/max speed
// predicts every read. Each returned bin is checked field by field against
// the oldest pending prediction. Both channels idle at random, and one phase
// holds off the result side long enough to stall the request side.
// ----------------------------------------------------------------------------
module tb_masked_per_minute_averager;

  localparam logic [mpma_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int QUIET_CYCLES = mpma_pkg::MINUTES_PER_DAY + 256;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int HOLD_CYCLES  = 1000;
  localparam int LIMIT_NS     = 3000000;
  localparam logic [mpma_pkg::SUM_W-1:0] SUM_CAP = '1;

  // One command on the request channel; value[0..4] are speed, flow,
  // cumulative flow, density and travel time index
  typedef struct packed {
    logic [mpma_pkg::CMD_W-1:0]                        command;
    logic [mpma_pkg::MINUTE_W-1:0]                     minute;
    logic [mpma_pkg::DAY_W-1:0]                        day;
    logic [mpma_pkg::EVENT_W-1:0]                      event_code;
    logic [mpma_pkg::N_SUMS-1:0][mpma_pkg::VAL_W-1:0]  value;
  } sample_cmd_t;

  // One returned bin
  typedef struct packed {
    logic [mpma_pkg::MINUTE_W-1:0]                     bin_minute;
    logic [mpma_pkg::COUNT_W-1:0]                      count;
    logic [mpma_pkg::N_SUMS-1:0][mpma_pkg::VAL_W-1:0]  mean;
    logic [mpma_pkg::VAL_W-1:0]                        min_speed;
    logic [mpma_pkg::VAL_W-1:0]                        max_speed;
  } bin_mean_t;

  logic clk = 1'b0;
  logic rst;

  mpma_req_if req_ch ();
  mpma_rsp_if rsp_ch ();
  mpma_cfg_if cfg_ch ();

  masked_per_minute_averager dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  always #1 clk = ~clk;

  // Predicted store and register shadows
  logic [mpma_pkg::SUM_W-1:0]    bin_sum [mpma_pkg::N_SUMS][mpma_pkg::MINUTES_PER_DAY];
  logic [mpma_pkg::COUNT_W-1:0]  bin_cnt [mpma_pkg::MINUTES_PER_DAY];
  logic [mpma_pkg::VAL_W-1:0]    win_min_spd;
  logic [mpma_pkg::VAL_W-1:0]    win_max_spd;
  logic [mpma_pkg::COUNT_W-1:0]  days_used;
  logic [mpma_pkg::MINUTE_W-1:0] win_first;
  logic [mpma_pkg::MINUTE_W-1:0] win_stop;

  bin_mean_t pending_means [$];
  logic [mpma_pkg::MINUTE_W-1:0] hot_min [8];
  string mean_name [mpma_pkg::N_SUMS] = '{"mean_speed", "mean_flow",
                                          "mean_cumulative_flow", "mean_density",
                                          "mean_travel_time_index"};

  bit   idle_en  = 1'b1;
  logic rsp_hold = 1'b0;
  int   rsp_wait = 0;

  int n_errors = 0;
  int n_items = 0;
  int n_reads = 0;
  int n_clears = 0;
  int n_writes = 0;
  int n_phases = 0;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  task automatic wipe_store();
    for (int m = 0; m < mpma_pkg::MINUTES_PER_DAY; m++) begin
      bin_cnt[m] = '0;
      for (int k = 0; k < mpma_pkg::N_SUMS; k++) bin_sum[k][m] = '0;
    end
    win_min_spd = mpma_pkg::LOWEST_RESET;
    win_max_spd = mpma_pkg::HIGHEST_RESET;
  endtask

  // Update the store for one accepted command; queue the bin a read returns
  task automatic apply_command(input sample_cmd_t c);
    logic [mpma_pkg::SUM_W:0]   total;
    bin_mean_t                  r;
    logic [mpma_pkg::SUM_W-1:0] s;
    case (c.command)
      mpma_pkg::CMD_CLEAR: begin
        wipe_store();
        n_clears++;
      end
      mpma_pkg::CMD_ADD: begin
        if (c.minute < mpma_pkg::MINUTES_PER_DAY && c.event_code == '0 &&
            c.day < days_used && c.day < mpma_pkg::MAX_DAYS &&
            bin_cnt[c.minute] < mpma_pkg::COUNT_MAX) begin
          for (int k = 0; k < mpma_pkg::N_SUMS; k++) begin
            total = {1'b0, bin_sum[k][c.minute]} + c.value[k];
            bin_sum[k][c.minute] = (total > SUM_CAP) ? SUM_CAP
                                                     : total[mpma_pkg::SUM_W-1:0];
          end
          bin_cnt[c.minute] = bin_cnt[c.minute] + 1'b1;
          if (c.minute >= win_first && c.minute < win_stop) begin
            if (c.value[0] < win_min_spd) win_min_spd = c.value[0];
            if (c.value[0] > win_max_spd) win_max_spd = c.value[0];
          end
        end
      end
      mpma_pkg::CMD_READ: begin
        r.bin_minute = c.minute;
        r.count = (c.minute < mpma_pkg::MINUTES_PER_DAY) ? bin_cnt[c.minute] : '0;
        for (int k = 0; k < mpma_pkg::N_SUMS; k++) begin
          s = (c.minute < mpma_pkg::MINUTES_PER_DAY) ? bin_sum[k][c.minute] : '0;
          r.mean[k] = (r.count == 0) ? '0 : mpma_pkg::VAL_W'(s / r.count);
        end
        r.min_speed = win_min_spd;
        r.max_speed = win_max_spd;
        pending_means = {pending_means, r};
      end
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Reporting and result checking
  // --------------------------------------------------------------------------
  task automatic report_error(input string msg);
    n_errors++;
    $display("[%0t] ERROR: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want, input int minute);
    if (got !== want)
      report_error($sformatf("bin %0d %s: got 0x%0h, expected 0x%0h",
                             minute, name, got, want));
  endtask

  task automatic check_result();
    bin_mean_t                  want;
    logic [mpma_pkg::VAL_W-1:0] got_mean [mpma_pkg::N_SUMS];
    if (pending_means.size() == 0) begin
      report_error($sformatf("result for bin %0d with nothing pending",
                             rsp_ch.bin_minute));
      return;
    end
    want = pending_means.pop_front();
    got_mean = '{rsp_ch.mean_speed, rsp_ch.mean_flow, rsp_ch.mean_cumulative_flow,
                 rsp_ch.mean_density, rsp_ch.mean_travel_time_index};
    compare_field("bin_minute", rsp_ch.bin_minute, want.bin_minute, want.bin_minute);
    compare_field("sample_count", rsp_ch.sample_count, want.count, want.bin_minute);
    for (int k = 0; k < mpma_pkg::N_SUMS; k++)
      compare_field(mean_name[k], got_mean[k], want.mean[k], want.bin_minute);
    compare_field("window_min_speed", rsp_ch.window_min_speed, want.min_speed,
                  want.bin_minute);
    compare_field("window_max_speed", rsp_ch.window_max_speed, want.max_speed,
                  want.bin_minute);
    n_reads++;
  endtask

  // Result side: check each transfer, then stall a random number of cycles
  initial begin : result_sink
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
        check_result();
        rsp_wait = idle_en ? $urandom_range(0, 19) : 0;
      end else if (rsp_ch.valid === 1'b1 && rsp_wait > 0) begin
        rsp_wait--;
      end
      rsp_ch.ready <= !rsp_hold && (rsp_wait == 0);
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Offer one command after a random gap; valid stays high for the next one
  task automatic send_item(input sample_cmd_t c);
    int unsigned gap;
    gap = idle_en ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid             <= 1'b1;
    req_ch.command           <= c.command;
    req_ch.minute            <= c.minute;
    req_ch.day               <= c.day;
    req_ch.event_code        <= c.event_code;
    req_ch.speed             <= c.value[0];
    req_ch.flow              <= c.value[1];
    req_ch.cumulative_flow   <= c.value[2];
    req_ch.density           <= c.value[3];
    req_ch.travel_time_index <= c.value[4];
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    apply_command(c);
    n_items++;
  endtask

  // Write one register; the caller drops valid after its last write
  task automatic write_reg(input logic [mpma_pkg::CFG_IDX_W-1:0] idx, input int data);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= mpma_pkg::CFG_DATA_W'(data);
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    case (idx)
      mpma_pkg::REG_DAY_COUNT:  days_used = mpma_pkg::COUNT_W'(data);
      mpma_pkg::REG_PEAK_START: win_first = mpma_pkg::MINUTE_W'(data);
      mpma_pkg::REG_PEAK_END:   win_stop  = mpma_pkg::MINUTE_W'(data);
      default: ;
    endcase
    n_writes++;
  endtask

  // Drop valid, wait for all pending bins, then let a clear sweep finish
  task automatic settle_block();
    req_ch.valid <= 1'b0;
    for (int i = 0; i < DRAIN_LIMIT && pending_means.size() != 0; i++) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
    if (pending_means.size() != 0) begin
      report_error($sformatf("%0d read results never arrived", pending_means.size()));
      pending_means.delete();
    end
  endtask

  task automatic set_registers(input int dc, input int ps, input int pe);
    write_reg(mpma_pkg::REG_DAY_COUNT, dc);
    write_reg(mpma_pkg::REG_PEAK_START, ps);
    write_reg(mpma_pkg::REG_PEAK_END, pe);
    cfg_ch.valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic sample_cmd_t make_cmd(input logic [mpma_pkg::CMD_W-1:0] cmd,
                                           input int minute, input int day,
                                           input int ev,
                                           input logic [mpma_pkg::VAL_W-1:0] spd,
                                           input logic [mpma_pkg::VAL_W-1:0] rest);
    sample_cmd_t c;
    c.command    = cmd;
    c.minute     = mpma_pkg::MINUTE_W'(minute);
    c.day        = mpma_pkg::DAY_W'(day);
    c.event_code = mpma_pkg::EVENT_W'(ev);
    c.value[0]   = spd;
    for (int k = 1; k < mpma_pkg::N_SUMS; k++)
      c.value[k] = rest ^ mpma_pkg::VAL_W'(k * 'h111);
    return c;
  endfunction

  function automatic logic [mpma_pkg::VAL_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return mpma_pkg::VAL_W'($urandom);
    endcase
  endfunction

  function automatic logic [mpma_pkg::MINUTE_W-1:0] clip_minute(input int m);
    if (m < 0) return '0;
    if (m > mpma_pkg::MINUTES_PER_DAY - 1)
      return mpma_pkg::MINUTE_W'(mpma_pkg::MINUTES_PER_DAY - 1);
    return mpma_pkg::MINUTE_W'(m);
  endfunction

  // Concentrate traffic on window edges, the first and last bins and two random bins
  task automatic choose_hot_minutes();
    hot_min[0] = clip_minute(win_first);
    hot_min[1] = clip_minute(int'(win_first) - 1);
    hot_min[2] = clip_minute(int'(win_stop) - 1);
    hot_min[3] = clip_minute(win_stop);
    hot_min[4] = '0;
    hot_min[5] = clip_minute(mpma_pkg::MINUTES_PER_DAY - 1);
    hot_min[6] = clip_minute($urandom_range(0, mpma_pkg::MINUTES_PER_DAY - 1));
    hot_min[7] = clip_minute($urandom_range(0, mpma_pkg::MINUTES_PER_DAY - 1));
  endtask

  function automatic logic [mpma_pkg::MINUTE_W-1:0] pick_minute();
    case ($urandom_range(0, 19))
      0:                      return mpma_pkg::MINUTE_W'(
                                       $urandom_range(mpma_pkg::MINUTES_PER_DAY, 2047));
      1, 2, 3, 4, 5, 6, 7, 8,
      9, 10, 11, 12:          return hot_min[$urandom_range(0, 7)];
      default:                return mpma_pkg::MINUTE_W'(
                                       $urandom_range(0, mpma_pkg::MINUTES_PER_DAY - 1));
    endcase
  endfunction

  // Mostly well-formed adds and reads; some rejected samples and odd commands
  function automatic sample_cmd_t rand_command();
    sample_cmd_t c;
    int unsigned pick;
    c.minute     = pick_minute();
    c.day        = mpma_pkg::DAY_W'($urandom);
    c.event_code = mpma_pkg::EVENT_W'($urandom);
    for (int k = 0; k < mpma_pkg::N_SUMS; k++) c.value[k] = rand_value();
    pick = $urandom_range(0, 199);
    if (pick < 3) begin
      c.command = mpma_pkg::CMD_CLEAR;
    end else if (pick < 6) begin
      c.command = CMD_UNUSED;
    end else if (pick < 76) begin
      c.command = mpma_pkg::CMD_READ;
    end else begin
      c.command    = mpma_pkg::CMD_ADD;
      c.event_code = '0;
      if (days_used != 0) c.day = mpma_pkg::DAY_W'($urandom_range(0, days_used - 1));
      if ($urandom_range(0, 4) == 0) begin
        // Break the sample: incident flagged or day past the limit
        if (days_used <= 63 && $urandom_range(0, 1) == 0)
          c.day = mpma_pkg::DAY_W'($urandom_range(days_used, 63));
        else
          c.event_code = mpma_pkg::EVENT_W'($urandom_range(1, 65535));
      end
    end
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Field extremes, every command and the corner cases at reset settings
  task automatic test_directed_cases();
    send_item(make_cmd(mpma_pkg::CMD_READ, 0, 0, 0, '0, '0));
    send_item(make_cmd(mpma_pkg::CMD_ADD, 480, 0, 0, '1, '1));
    send_item(make_cmd(mpma_pkg::CMD_ADD, 539, 0, 0, '0, '0));
    send_item(make_cmd(mpma_pkg::CMD_ADD, 540, 0, 0, 24'd100, 24'h5A5A5A));
    send_item(make_cmd(mpma_pkg::CMD_ADD, 479, 0, 0, 24'd5, 24'hA5A5A5));
    send_item(make_cmd(mpma_pkg::CMD_ADD, 480, 0, 'hFFFF, 24'd1, 24'h123456));
    send_item(make_cmd(mpma_pkg::CMD_ADD, 480, 1, 0, 24'd2, 24'h654321));
    send_item(make_cmd(mpma_pkg::CMD_ADD, 480, 63, 0, 24'd3, '1));
    send_item(make_cmd(mpma_pkg::CMD_ADD, mpma_pkg::MINUTES_PER_DAY, 0, 0, 24'd4, '1));
    send_item(make_cmd(mpma_pkg::CMD_ADD, 2047, 0, 0, 24'd6, '1));
    send_item(make_cmd(CMD_UNUSED, 480, 0, 0, 24'd7, '1));
    send_item(make_cmd(mpma_pkg::CMD_ADD, 0, 0, 0, 24'h000321, 24'hFFFFF0));
    send_item(make_cmd(mpma_pkg::CMD_ADD, mpma_pkg::MINUTES_PER_DAY - 1, 0, 0,
                       24'hFFFFFE, 24'h00000F));
    send_item(make_cmd(mpma_pkg::CMD_READ, 480, 63, 'hFFFF, '1, '1));
    send_item(make_cmd(mpma_pkg::CMD_READ, 539, 0, 0, '0, '0));
    send_item(make_cmd(mpma_pkg::CMD_READ, 540, 0, 0, '0, '0));
    send_item(make_cmd(mpma_pkg::CMD_READ, 479, 0, 0, '0, '0));
    send_item(make_cmd(mpma_pkg::CMD_READ, mpma_pkg::MINUTES_PER_DAY, 0, 0, '0, '0));
    send_item(make_cmd(mpma_pkg::CMD_READ, 2047, 0, 0, '0, '0));
    send_item(make_cmd(mpma_pkg::CMD_READ, 0, 0, 0, '0, '0));
    send_item(make_cmd(mpma_pkg::CMD_READ, mpma_pkg::MINUTES_PER_DAY - 1, 0, 0, '0, '0));
    send_item(make_cmd(mpma_pkg::CMD_CLEAR, 2047, 63, 'hFFFF, '1, '1));
    send_item(make_cmd(mpma_pkg::CMD_READ, 480, 0, 0, '0, '0));
    send_item(make_cmd(mpma_pkg::CMD_READ, 539, 0, 0, '0, '0));
  endtask

  // Random traffic under a range of day limits and window placements
  task automatic test_config_sweep();
    int dc [8];
    int ps [8];
    int pe [8];
    dc = '{64, 0, 1, 37, 20, 0, 0, 0};
    ps = '{0, 480, 1439, 900, 700, 0, 0, 0};
    pe = '{1440, 540, 1440, 300, 700, 0, 0, 0};
    for (int p = 5; p < 8; p++) begin
      dc[p] = $urandom_range(1, 64);
      ps[p] = $urandom_range(0, mpma_pkg::MINUTES_PER_DAY - 1);
      pe[p] = $urandom_range(ps[p], mpma_pkg::MINUTES_PER_DAY);
    end
    for (int p = 0; p < 8; p++) begin
      settle_block();
      set_registers(dc[p], ps[p], pe[p]);
      idle_en <= (p % 3 != 1);
      choose_hot_minutes();
      n_phases++;
      repeat (140) send_item(rand_command());
    end
  endtask

  // Overload one bin: sums saturate, then the count stops at its maximum
  task automatic test_bin_saturation();
    settle_block();
    set_registers(64, 0, mpma_pkg::MINUTES_PER_DAY);
    idle_en <= 1'b0;
    send_item(make_cmd(mpma_pkg::CMD_CLEAR, 0, 0, 0, '0, '0));
    for (int i = 0; i < 130; i++) begin
      send_item(make_cmd(mpma_pkg::CMD_ADD, 1000, $urandom_range(0, 63), 0, '1, '1));
      if (i % 32 == 31) send_item(make_cmd(mpma_pkg::CMD_READ, 1000, 0, 0, '0, '0));
    end
    send_item(make_cmd(mpma_pkg::CMD_READ, 1000, 0, 0, '0, '0));
  endtask

  // Hold off results while reads keep coming, so the request side stalls
  task automatic test_output_backpressure();
    settle_block();
    idle_en <= 1'b0;
    choose_hot_minutes();
    fork
      begin
        rsp_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_hold <= 1'b0;
      end
    join_none
    for (int i = 0; i < 40; i++) begin
      if (i % 2 == 0)
        send_item(make_cmd(mpma_pkg::CMD_READ, pick_minute(), 0, 0, '0, '0));
      else
        send_item(make_cmd(mpma_pkg::CMD_ADD, hot_min[$urandom_range(0, 7)],
                           $urandom_range(0, 63), 0, rand_value(), rand_value()));
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : main_sequence
    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.command    <= mpma_pkg::CMD_READ;
    req_ch.minute     <= '0;
    req_ch.day        <= '0;
    req_ch.event_code <= '0;
    req_ch.speed      <= '0;
    req_ch.flow       <= '0;
    req_ch.cumulative_flow   <= '0;
    req_ch.density           <= '0;
    req_ch.travel_time_index <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.reg_index <= mpma_pkg::REG_DAY_COUNT;
    cfg_ch.wdata     <= '0;
    days_used = mpma_pkg::DAY_COUNT_RESET;
    win_first = mpma_pkg::PEAK_START_RESET;
    win_stop  = mpma_pkg::PEAK_END_RESET;
    wipe_store();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_config_sweep();
    test_bin_saturation();
    test_output_backpressure();
    settle_block();

    $display("Run covered %0d commands: %0d bins read back, %0d clears, %0d register writes",
             n_items, n_reads, n_clears, n_writes);
    $display("Swept %0d day/window settings, count saturation and a long result stall",
             n_phases);
    if (n_errors == 0) begin
      $display("masked_per_minute_averager regression: pass");
    end else begin
      $display("masked_per_minute_averager regression: fail");
    end
    $finish;
  end

  // Hard stop if the block hangs
  initial begin : watchdog
    #(LIMIT_NS);
    $display("Timeout with %0d reads still pending", pending_means.size());
    $display("masked_per_minute_averager regression: fail");
    $finish;
  end

endmodule

/* files.f */
design/mpma_pkg.sv
design/mpma_ifs.sv
design/mpma_store.sv
design/mpma_div.sv
design/masked_per_minute_averager.sv
tb/sv/tb_masked_per_minute_averager.sv
